// File: rtl/ultrasonic_echo_range_averager_macros.svh
// Assertion macros used by the port checker of the echo range averager.
`ifndef ULTRASONIC_ECHO_RANGE_AVERAGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGE_AVERAGER_MACROS_SVH

// General property on clk, off while rst_n is low.
`define UERA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("echo range averager port check failed");

// Check expr on every clock edge at which cond holds.
`define UERA_ASSERT_WHEN(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("echo range averager field check failed");

`endif

// File: rtl/uera_pkg.sv
// Shared types, codes and fixed constants of the echo range averager.
package uera_pkg;

    localparam int ECHO_W     = 24;
    localparam int CM_W       = 10;
    localparam int TENTHS_W   = 4;
    localparam int SUM_W      = 22;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Output word layout, lowest bit first.
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_IND_LSB    = 2;
    localparam int OUT_WHOLE_LSB  = 4;
    localparam int OUT_TENTHS_LSB = 14;
    localparam int OUT_USED_W     = 18;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Tenths of cm = sum * 3430 / (100000 * samples).
    localparam int  SOUND_X10   = 3430;
    localparam int  CM_SCALE    = 100000;
    localparam int  RECIP_SHIFT = 23;
    localparam int  RECIP_W     = 19;
    localparam int  TENTHS_TOT_W = 18;
    localparam int  NUM_W       = 34;

    // Exact divide by ten for values below 10240.
    localparam int  DIV10_MUL   = 52429;
    localparam int  DIV10_SHIFT = 19;
    localparam int  DIV10_IN_W  = 14;
    localparam logic [TENTHS_TOT_W-1:0] TENTHS_SAT = 18'd10240;
    localparam logic [CM_W-1:0]     WHOLE_MAX  = 10'd1023;
    localparam logic [TENTHS_W-1:0] TENTH_MAX  = 4'd9;

    localparam logic [ECHO_W-1:0] MIN_ECHO_RST = 24'd9329;
    localparam logic [ECHO_W-1:0] MAX_ECHO_RST = 24'd1865889;
    localparam logic [CM_W-1:0]   NEAR_LO_RST  = 10'd5;
    localparam logic [CM_W-1:0]   NEAR_HI_RST  = 10'd25;
    localparam logic [CM_W-1:0]   MID_LO_RST   = 10'd26;
    localparam logic [CM_W-1:0]   MID_HI_RST   = 10'd50;
    localparam logic [CM_W-1:0]   FAR_LO_RST   = 10'd51;
    localparam logic [CM_W-1:0]   FAR_HI_RST   = 10'd400;

    typedef enum logic [1:0] {
        STATUS_ACC = 2'd0,
        STATUS_AVG = 2'd1,
        STATUS_ERR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        IND_NONE  = 2'd0,
        IND_RED   = 2'd1,
        IND_BLUE  = 2'd2,
        IND_GREEN = 2'd3
    } indicator_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ECHO = 3'd0,
        CFG_MAX_ECHO = 3'd1,
        CFG_NEAR_LO  = 3'd2,
        CFG_NEAR_HI  = 3'd3,
        CFG_MID_LO   = 3'd4,
        CFG_MID_HI   = 3'd5,
        CFG_FAR_LO   = 3'd6,
        CFG_FAR_HI   = 3'd7
    } cfg_idx_t;

endpackage

// File: rtl/ultrasonic_echo_range_averager.sv
// Echo range averager: windowed echo accumulate, exact cm average, band indicator.
// Throughput: one word per cycle unless m_tready is low with every stage full; six
// registered stages (input, accumulate, reciprocal multiply, remainder correction,
// divide by ten, output) advance and fill bubbles.
// Reset (rst_n low, asynchronous): pipeline empty, sum and count zero, window and
// band registers back to their defaults.
module ultrasonic_echo_range_averager #(
    parameter int SAMPLES_PER_AVERAGE = 25
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [uera_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [uera_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // echo words in
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [uera_pkg::IN_TDATA_W-1:0]       s_tdata,   // [23:0] echo_cycles
    // result words out
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [1:0] status, [3:2] indicator, [13:4] whole_cm, [17:14] tenths_cm, [23:18] zero
    output logic [uera_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int NSTG = 6;
    // Denominator of the tenths quotient and its truncated reciprocal.
    localparam longint DEN     = longint'(uera_pkg::CM_SCALE) * SAMPLES_PER_AVERAGE;
    localparam longint RECIP_L = (longint'(uera_pkg::SOUND_X10) << uera_pkg::RECIP_SHIFT)
                                 / DEN;
    localparam logic [uera_pkg::RECIP_W-1:0] RECIP = uera_pkg::RECIP_W'(RECIP_L);
    localparam logic [uera_pkg::NUM_W-1:0]   DEN_N = uera_pkg::NUM_W'(DEN);
    localparam logic [uera_pkg::CNT_W:0]     SAMPLES = (uera_pkg::CNT_W+1)'(SAMPLES_PER_AVERAGE);

    localparam int PROD_W  = uera_pkg::SUM_W + uera_pkg::RECIP_W;
    localparam int TDEN_W  = uera_pkg::TENTHS_TOT_W + uera_pkg::NUM_W;
    localparam int DIV10_W = uera_pkg::DIV10_IN_W + 16;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [uera_pkg::ECHO_W-1:0] min_echo_reg, max_echo_reg;
    logic [uera_pkg::CM_W-1:0]   near_lo_reg, near_hi_reg, mid_lo_reg, mid_hi_reg;
    logic [uera_pkg::CM_W-1:0]   far_lo_reg, far_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_echo_reg <= uera_pkg::MIN_ECHO_RST;
            max_echo_reg <= uera_pkg::MAX_ECHO_RST;
            near_lo_reg  <= uera_pkg::NEAR_LO_RST;
            near_hi_reg  <= uera_pkg::NEAR_HI_RST;
            mid_lo_reg   <= uera_pkg::MID_LO_RST;
            mid_hi_reg   <= uera_pkg::MID_HI_RST;
            far_lo_reg   <= uera_pkg::FAR_LO_RST;
            far_hi_reg   <= uera_pkg::FAR_HI_RST;
        end
        else if (cfg_wr_en)
        begin
            // Every 3-bit index names a register; 10-bit bands take the low bits.
            unique case (uera_pkg::cfg_idx_t'(cfg_addr))
                uera_pkg::CFG_MIN_ECHO: min_echo_reg <= cfg_wdata;
                uera_pkg::CFG_MAX_ECHO: max_echo_reg <= cfg_wdata;
                uera_pkg::CFG_NEAR_LO:  near_lo_reg  <= cfg_wdata[uera_pkg::CM_W-1:0];
                uera_pkg::CFG_NEAR_HI:  near_hi_reg  <= cfg_wdata[uera_pkg::CM_W-1:0];
                uera_pkg::CFG_MID_LO:   mid_lo_reg   <= cfg_wdata[uera_pkg::CM_W-1:0];
                uera_pkg::CFG_MID_HI:   mid_hi_reg   <= cfg_wdata[uera_pkg::CM_W-1:0];
                uera_pkg::CFG_FAR_LO:   far_lo_reg   <= cfg_wdata[uera_pkg::CM_W-1:0];
                uera_pkg::CFG_FAR_HI:   far_hi_reg   <= cfg_wdata[uera_pkg::CM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // successor loads, so bubbles collapse and a full output still
    // lets upstream words move up.
    // ---------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG-2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage load strobes: the stage takes a real word this edge.
    logic [NSTG-1:0] ld;
    always_comb
    begin
        ld[0] = rdy[0] && s_tvalid;
        for (int i = 1; i < NSTG; i++)
        begin
            ld[i] = rdy[i] && vld_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: input register
    // ---------------------------------------------------------------
    logic [uera_pkg::ECHO_W-1:0] echo_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            echo_reg <= s_tdata[uera_pkg::ECHO_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: window check and accumulate. The running sum and count
    // change only when a word moves from stage 0 to stage 1.
    // ---------------------------------------------------------------
    logic [uera_pkg::SUM_W-1:0] sample_sum_reg, sample_sum_next;
    logic [uera_pkg::CNT_W-1:0] sample_count_reg, sample_count_next;
    uera_pkg::status_t          acc_status_reg, acc_status_next;
    logic [uera_pkg::SUM_W-1:0] acc_sum_reg, acc_sum_next;

    logic                       echo_bad;
    logic [uera_pkg::SUM_W:0]   sum_wide;
    logic [uera_pkg::SUM_W-1:0] sum_sat;
    logic [uera_pkg::CNT_W:0]   count_inc;

    always_comb
    begin
        echo_bad  = (echo_reg < min_echo_reg) || (echo_reg > max_echo_reg);
        // Add floor(echo / 16), saturate at the top of the 22-bit sum.
        sum_wide  = {1'b0, sample_sum_reg}
                  + (uera_pkg::SUM_W+1)'(echo_reg >> 4);
        sum_sat   = sum_wide[uera_pkg::SUM_W] ? uera_pkg::SUM_MAX
                                              : sum_wide[uera_pkg::SUM_W-1:0];
        count_inc = {1'b0, sample_count_reg} + (uera_pkg::CNT_W+1)'(1);

        sample_sum_next   = sample_sum_reg;
        sample_count_next = sample_count_reg;
        acc_sum_next      = sum_sat;
        acc_status_next   = uera_pkg::STATUS_ACC;

        if (echo_bad)
        begin
            // Out of window: report, leave the running state alone.
            acc_status_next = uera_pkg::STATUS_ERR;
        end
        else if (count_inc >= SAMPLES)
        begin
            acc_status_next   = uera_pkg::STATUS_AVG;
            sample_sum_next   = '0;
            sample_count_next = '0;
        end
        else
        begin
            sample_sum_next   = sum_sat;
            sample_count_next = count_inc[uera_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
        end
        else if (ld[1])
        begin
            sample_sum_reg   <= sample_sum_next;
            sample_count_reg <= sample_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            acc_status_reg <= acc_status_next;
            acc_sum_reg    <= acc_sum_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: estimate tenths = floor(sum * 3430 / DEN) by a truncated
    // reciprocal. The estimate is the true value or one below it.
    // ---------------------------------------------------------------
    uera_pkg::status_t                  mul_status_reg;
    logic [uera_pkg::SUM_W-1:0]         mul_sum_reg;
    logic [uera_pkg::TENTHS_TOT_W-1:0]  mul_est_reg;
    logic [PROD_W-1:0]                  recip_prod;

    assign recip_prod = PROD_W'(acc_sum_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            mul_status_reg <= acc_status_reg;
            mul_sum_reg    <= acc_sum_reg;
            mul_est_reg    <= recip_prod[uera_pkg::RECIP_SHIFT +: uera_pkg::TENTHS_TOT_W];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: remainder against the exact numerator, correct the
    // estimate by one and note whether the quotient is exact.
    // ---------------------------------------------------------------
    uera_pkg::status_t                  rem_status_reg;
    logic [uera_pkg::TENTHS_TOT_W-1:0]  rem_tenths_reg;
    logic                               rem_zero_reg;

    logic [uera_pkg::NUM_W-1:0] num10;
    logic [TDEN_W-1:0]          est_den;
    logic [uera_pkg::NUM_W-1:0] rem_raw;
    logic                       rem_corr;

    always_comb
    begin
        num10    = uera_pkg::NUM_W'(mul_sum_reg) * uera_pkg::NUM_W'(uera_pkg::SOUND_X10);
        est_den  = TDEN_W'(mul_est_reg) * TDEN_W'(DEN_N);
        rem_raw  = num10 - est_den[uera_pkg::NUM_W-1:0];
        rem_corr = (rem_raw >= DEN_N);
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            rem_status_reg <= mul_status_reg;
            rem_tenths_reg <= mul_est_reg + uera_pkg::TENTHS_TOT_W'(rem_corr);
            rem_zero_reg   <= rem_corr ? (rem_raw == DEN_N) : (rem_raw == '0);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: split tenths into whole cm; values of 1024 cm and up
    // only need the flag.
    // ---------------------------------------------------------------
    uera_pkg::status_t                 div_status_reg;
    logic                              div_big_reg;
    logic                              div_rem_zero_reg;
    logic [uera_pkg::DIV10_IN_W-1:0]   div_tenths_reg;
    logic [uera_pkg::CM_W-1:0]         div_whole_reg;
    logic [DIV10_W-1:0]                div10_prod;

    assign div10_prod = DIV10_W'(rem_tenths_reg[uera_pkg::DIV10_IN_W-1:0])
                      * DIV10_W'(uera_pkg::DIV10_MUL);

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            div_status_reg   <= rem_status_reg;
            div_big_reg      <= (rem_tenths_reg >= uera_pkg::TENTHS_SAT);
            div_rem_zero_reg <= rem_zero_reg;
            div_tenths_reg   <= rem_tenths_reg[uera_pkg::DIV10_IN_W-1:0];
            div_whole_reg    <= div10_prod[uera_pkg::DIV10_SHIFT +: uera_pkg::CM_W];
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: tenths digit, saturation, band match, output register.
    // ---------------------------------------------------------------
    // True when the exact average A lies in [lo, hi]; whole is floor(A)
    // widened so 1024 stands for anything past the 10-bit range.
    function automatic logic in_band(input logic [uera_pkg::CM_W:0]   whole,
                                     input logic                      exact,
                                     input logic [uera_pkg::CM_W-1:0] lo,
                                     input logic [uera_pkg::CM_W-1:0] hi);
        logic [uera_pkg::CM_W:0] lo_w;
        logic [uera_pkg::CM_W:0] hi_w;
        lo_w = {1'b0, lo};
        hi_w = {1'b0, hi};
        return (whole >= lo_w) && ((whole < hi_w) || ((whole == hi_w) && exact));
    endfunction

    uera_pkg::status_t           out_status_reg, out_status_next;
    uera_pkg::indicator_t        out_ind_reg, out_ind_next;
    logic [uera_pkg::CM_W-1:0]   out_whole_reg, out_whole_next;
    logic [uera_pkg::TENTHS_W-1:0] out_tenth_reg, out_tenth_next;

    logic [uera_pkg::DIV10_IN_W-1:0] whole_x10;
    logic [uera_pkg::DIV10_IN_W-1:0] tenth_wide;
    logic [uera_pkg::TENTHS_W-1:0]   tenth;
    logic                            avg_exact;
    logic [uera_pkg::CM_W:0]         whole_ext;

    always_comb
    begin
        whole_x10  = (uera_pkg::DIV10_IN_W'(div_whole_reg) << 3)
                   + (uera_pkg::DIV10_IN_W'(div_whole_reg) << 1);
        tenth_wide = div_tenths_reg - whole_x10;
        tenth      = tenth_wide[uera_pkg::TENTHS_W-1:0];
        avg_exact  = div_rem_zero_reg && (tenth == '0);
        whole_ext  = div_big_reg ? {1'b1, {uera_pkg::CM_W{1'b0}}}
                                 : {1'b0, div_whole_reg};

        out_status_next = div_status_reg;
        out_ind_next    = uera_pkg::IND_NONE;
        out_whole_next  = '0;
        out_tenth_next  = '0;

        unique case (div_status_reg)
            uera_pkg::STATUS_ERR:
            begin
                out_ind_next = uera_pkg::IND_RED;
            end
            uera_pkg::STATUS_AVG:
            begin
                out_whole_next = div_big_reg ? uera_pkg::WHOLE_MAX : div_whole_reg;
                out_tenth_next = div_big_reg ? uera_pkg::TENTH_MAX : tenth;
                // Near band first, then middle, then far; gaps give no indicator.
                priority if (in_band(whole_ext, avg_exact, near_lo_reg, near_hi_reg))
                    out_ind_next = uera_pkg::IND_RED;
                else if (in_band(whole_ext, avg_exact, mid_lo_reg, mid_hi_reg))
                    out_ind_next = uera_pkg::IND_BLUE;
                else if (in_band(whole_ext, avg_exact, far_lo_reg, far_hi_reg))
                    out_ind_next = uera_pkg::IND_GREEN;
                else
                    out_ind_next = uera_pkg::IND_NONE;
            end
            default:
            begin
                out_ind_next = uera_pkg::IND_NONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            out_status_reg <= out_status_next;
            out_ind_reg    <= out_ind_next;
            out_whole_reg  <= out_whole_next;
            out_tenth_reg  <= out_tenth_next;
        end
    end

    assign m_tdata = {(uera_pkg::OUT_TDATA_W - uera_pkg::OUT_USED_W)'(0),
                      out_tenth_reg, out_whole_reg, out_ind_reg, out_status_reg};

endmodule

// File: rtl/uera_port_checker.sv
// Port-level checker for the echo range averager, bound to the top level.
`include "ultrasonic_echo_range_averager_macros.svh"

module uera_port_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [uera_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic [1:0]                    st;
    logic [1:0]                    ind;
    logic [uera_pkg::CM_W-1:0]     whole;
    logic [uera_pkg::TENTHS_W-1:0] tenth;

    assign st    = m_tdata[uera_pkg::OUT_STATUS_LSB +: 2];
    assign ind   = m_tdata[uera_pkg::OUT_IND_LSB +: 2];
    assign whole = m_tdata[uera_pkg::OUT_WHOLE_LSB +: uera_pkg::CM_W];
    assign tenth = m_tdata[uera_pkg::OUT_TENTHS_LSB +: uera_pkg::TENTHS_W];

    // Stalled output word holds.
    `UERA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // Input only backs up when the output is full and stalled.
    `UERA_ASSERT_WHEN(a_in_stall, !s_tready, m_tvalid && !m_tready)
    // Out-of-window word: red, no distance.
    `UERA_ASSERT_WHEN(a_err_word, m_tvalid && st == uera_pkg::STATUS_ERR, ind == uera_pkg::IND_RED && whole == '0 && tenth == '0)
    // Accumulating word carries nothing else.
    `UERA_ASSERT_WHEN(a_acc_word, m_tvalid && st == uera_pkg::STATUS_ACC, ind == uera_pkg::IND_NONE && whole == '0 && tenth == '0)
    // Average word has a decimal tenths digit.
    `UERA_ASSERT_WHEN(a_avg_tenth, m_tvalid && st == uera_pkg::STATUS_AVG, tenth <= uera_pkg::TENTH_MAX)

endmodule

bind ultrasonic_echo_range_averager uera_port_checker u_port_checker (.*);
